// ----- src/ccs_pkg.sv -----
// Shared types and constants for the cable continuity scan unit.
// No dependencies; imported by ccs_table, ccs_scan, the top level and the testbench.
package ccs_pkg;

    localparam int MAX_LINES     = 16;
    localparam int LINES_DEFAULT = 16;
    localparam int LINE_W        = 4;
    localparam int ROW_W         = 16;
    localparam int CFG_REGS      = 4;
    localparam int ROWS_PER_REG  = 4;
    localparam int CFG_INDEX_W   = 8;
    localparam int CFG_DATA_W    = 64;
    localparam int IN_DATA_W     = 16;
    localparam int OUT_DATA_W    = 16;

    localparam logic OP_START    = 1'b0;
    localparam logic OP_READBACK = 1'b1;

    localparam logic PROBLEM_OPEN  = 1'b0;
    localparam logic PROBLEM_SHORT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] EXPECTED_RESET [CFG_REGS] = '{
        64'd2308112418536031297,
        64'd612494224396402704,
        64'd576465150383489280,
        64'd9223442406135828480
    };

    typedef struct packed {
        logic [LINE_W-1:0] drive_line;
        logic              done_res;
        logic              passed;
        logic [LINE_W-1:0] main_line;
        logic              problem_type;
        logic [LINE_W-1:0] second_line;
    } result_t;

endpackage

// ----- src/ccs_table.sv -----
// Expected connection table: one 16-bit row per line, loaded by register writes.
// Depends on ccs_pkg.
module ccs_table #(
    parameter int LINES = ccs_pkg::LINES_DEFAULT,
    parameter int LW    = (LINES > 1) ? $clog2(LINES) : 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [ccs_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [ccs_pkg::CFG_DATA_W-1:0]   wr_data,
    input  logic [LW-1:0]                    rd_line,
    output logic [ccs_pkg::ROW_W-1:0]        rd_row
);
    import ccs_pkg::*;

    logic [ROW_W-1:0] rows_reg [LINES];

    for (genvar r = 0; r < LINES; r++)
    begin : g_row
        localparam int REG_IDX = r / ROWS_PER_REG;
        localparam int ROW_LSB = ROW_W * (r % ROWS_PER_REG);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rows_reg[r] <= EXPECTED_RESET[REG_IDX][ROW_LSB +: ROW_W];
            end
            else if (wr_en && (wr_index == CFG_INDEX_W'(REG_IDX)))
            begin
                rows_reg[r] <= wr_data[ROW_LSB +: ROW_W];
            end
        end
    end

    assign rd_row = rows_reg[rd_line];

endmodule

// ----- src/ccs_scan.sv -----
// Scan sequencer: holds scan state and forms one result per input beat.
// Depends on ccs_pkg.
module ccs_scan #(
    parameter int LINES = ccs_pkg::LINES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic                          op,
    input  logic [ccs_pkg::ROW_W-1:0]     levels,
    input  logic [ccs_pkg::ROW_W-1:0]     row,
    output logic [ccs_pkg::LINE_W-1:0]    cur_line,
    output ccs_pkg::result_t              result
);
    import ccs_pkg::*;

    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(LINES - 1);

    logic              scanning_reg, scanning_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              passed_reg, passed_next;
    logic [LINE_W-1:0] fault_main_reg, fault_main_next;
    logic              fault_kind_reg, fault_kind_next;
    logic [LINE_W-1:0] fault_second_reg, fault_second_next;

    logic [ROW_W-1:0]  checked;
    logic [ROW_W-1:0]  diff;
    logic [LINE_W-1:0] first_bad;

    assign cur_line = line_reg;

    // Only lines above the driven one and below LINES are compared.
    always_comb
    begin
        for (int i = 0; i < ROW_W; i++)
        begin
            checked[i] = (i < LINES) && (LINE_W'(i) > line_reg);
        end
    end

    assign diff = (levels ^ row) & checked;

    always_comb
    begin
        first_bad = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (diff[i])
            begin
                first_bad = LINE_W'(i);
            end
        end
    end

    always_comb
    begin
        scanning_next     = scanning_reg;
        line_next         = line_reg;
        passed_next       = passed_reg;
        fault_main_next   = fault_main_reg;
        fault_kind_next   = fault_kind_reg;
        fault_second_next = fault_second_reg;
        result            = '0;

        if (op == OP_START)
        begin
            scanning_next = 1'b1;
            line_next     = '0;
        end
        else if (!scanning_reg)
        begin
            result.done_res     = 1'b1;
            result.passed       = passed_reg;
            result.main_line    = fault_main_reg;
            result.problem_type = fault_kind_reg;
            result.second_line  = fault_second_reg;
        end
        else if (diff != '0)
        begin
            scanning_next       = 1'b0;
            passed_next         = 1'b0;
            fault_main_next     = line_reg;
            fault_kind_next     = levels[first_bad] ? PROBLEM_SHORT : PROBLEM_OPEN;
            fault_second_next   = first_bad;
            result.done_res     = 1'b1;
            result.main_line    = fault_main_next;
            result.problem_type = fault_kind_next;
            result.second_line  = fault_second_next;
        end
        else if (line_reg >= LAST_LINE)
        begin
            scanning_next     = 1'b0;
            passed_next       = 1'b1;
            fault_main_next   = '0;
            fault_kind_next   = PROBLEM_OPEN;
            fault_second_next = '0;
            result.done_res   = 1'b1;
            result.passed     = 1'b1;
        end
        else
        begin
            line_next         = line_reg + LINE_W'(1);
            result.drive_line = line_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scanning_reg     <= 1'b0;
            line_reg         <= '0;
            passed_reg       <= 1'b0;
            fault_main_reg   <= '0;
            fault_kind_reg   <= 1'b0;
            fault_second_reg <= '0;
        end
        else if (fire)
        begin
            scanning_reg     <= scanning_next;
            line_reg         <= line_next;
            passed_reg       <= passed_next;
            fault_main_reg   <= fault_main_next;
            fault_kind_reg   <= fault_kind_next;
            fault_second_reg <= fault_second_next;
        end
    end

endmodule

// ----- src/cable_continuity_scan_unit.sv -----
// Cable continuity scan unit: top level with input and result registers.
// Input register feeds scan state and result register, which update in the same cycle.
// Throughput: one beat per cycle while the master side does not stall.
// Backpressure from the master side reaches s_axis_tready only when both registers are full.
// Reset (rst_n, async, active low) clears scan state and valid flags, reloads the table.
// Depends on ccs_pkg, ccs_table and ccs_scan.
module cable_continuity_scan_unit #(
    parameter int LINES = ccs_pkg::LINES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ccs_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // line_levels[15:0]
    input  logic                              s_axis_tuser,   // op
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // drive_line[3:0], passed[4], main_line[8:5], problem_type[9], second_line[13:10],
    // zero[15:14]
    output logic [ccs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast,   // done_res
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ccs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ccs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ccs_pkg::*;

    localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;

    logic             in_valid_reg, in_valid_next;
    logic             in_op_reg;
    logic [ROW_W-1:0] in_levels_reg;
    logic             out_valid_reg, out_valid_next;
    result_t          out_data_reg;

    logic              advance;
    logic [ROW_W-1:0]  row;
    logic [LINE_W-1:0] cur_line;
    result_t           result;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || !out_valid_reg || m_axis_tready;

    ccs_table #(
        .LINES (LINES),
        .LW    (LW)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .rd_line  (cur_line[LW-1:0]),
        .rd_row   (row)
    );

    ccs_scan #(
        .LINES (LINES)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .op       (in_op_reg),
        .levels   (in_levels_reg),
        .row      (row),
        .cur_line (cur_line),
        .result   (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the input beat until the result stage can take it.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_op_reg     <= s_axis_tuser;
            in_levels_reg <= s_axis_tdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_data_reg.done_res;
    assign m_axis_tdata  = {2'b00,
                            out_data_reg.second_line,
                            out_data_reg.problem_type,
                            out_data_reg.main_line,
                            out_data_reg.passed,
                            out_data_reg.drive_line};

endmodule

// ----- src/ccs_checker.sv -----
// Port-level checks for the cable continuity scan unit, bound to the top level.
// Depends only on the top level's ports.
module ccs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // Input side stalls only when the result side is full and stalled.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // While a scan runs, no verdict fields are shown.
    a_running_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[15:4] == 12'd0)
        else $error("verdict fields set while scanning");

    // A finished scan names no line to drive; a pass carries no fault.
    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[3:0] == 4'd0 &&
            (!m_axis_tdata[4] || m_axis_tdata[15:5] == 11'd0))
        else $error("inconsistent verdict beat");

endmodule

bind cable_continuity_scan_unit ccs_checker u_ccs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- tb/tb_cable_continuity_scan_unit.sv -----
// Self-checking testbench for cable_continuity_scan_unit: scans, faults, restarts, table writes.
// Keeps its own scan predictor and connection table; needs ccs_pkg and the unit's RTL.
module tb_cable_continuity_scan_unit;
    import ccs_pkg::*;

    localparam int HARNESS_LINES = 16;
    localparam int LAST_LINE     = HARNESS_LINES - 1;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 6;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    cable_continuity_scan_unit #(
        .LINES(HARNESS_LINES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Predictor state: connection table and scan progress
    logic [CFG_DATA_W-1:0] conn_table [CFG_REGS];
    logic                  scanning;
    logic [LINE_W-1:0]     cur_line;
    logic                  verdict_ok;
    logic [LINE_W-1:0]     fault_drive;
    logic                  fault_kind;
    logic [LINE_W-1:0]     fault_sense;

    result_t scan_results_due [$];

    int  errors;
    int  cycles;
    int  beats_sent;
    int  beats_checked;
    int  scans_passed;
    int  shorts_found;
    int  opens_found;
    int  restarts;
    int  table_writes;
    bit  idle_on;
    bit  quiet;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycles,
                     scan_results_due.size());
            $display("FAIL cable_continuity_scan_unit");
            $finish;
        end
    end

    function automatic logic [ROW_W-1:0] row_of(logic [LINE_W-1:0] ln);
        return conn_table[ln[3:2]][ln[1:0]*ROW_W +: ROW_W];
    endfunction

    // Only lines above the driven one are compared
    function automatic logic [ROW_W-1:0] checked_mask(logic [LINE_W-1:0] ln);
        return 16'hFFFF << (int'(ln) + 1);
    endfunction

    function automatic result_t stored_verdict();
        result_t r;
        r = '0;
        r.done_res     = 1'b1;
        r.passed       = verdict_ok;
        r.main_line    = fault_drive;
        r.problem_type = fault_kind;
        r.second_line  = fault_sense;
        return r;
    endfunction

    function automatic result_t predict_scan_result(logic op, logic [ROW_W-1:0] lv);
        result_t          r;
        logic [ROW_W-1:0] diff;
        int               bad;
        r = '0;
        if (op == OP_START)
        begin
            if (scanning)
                restarts++;
            scanning = 1'b1;
            cur_line = '0;
            return r;
        end
        if (!scanning)
            return stored_verdict();
        diff = (lv ^ row_of(cur_line)) & checked_mask(cur_line);
        if (diff != '0)
        begin
            bad = 0;
            while (!diff[bad])
                bad++;
            scanning    = 1'b0;
            verdict_ok  = 1'b0;
            fault_drive = cur_line;
            fault_kind  = lv[bad];
            fault_sense = LINE_W'(bad);
            if (lv[bad] == PROBLEM_SHORT)
                shorts_found++;
            else
                opens_found++;
            return stored_verdict();
        end
        if (cur_line == LINE_W'(LAST_LINE))
        begin
            scanning    = 1'b0;
            verdict_ok  = 1'b1;
            fault_drive = '0;
            fault_kind  = PROBLEM_OPEN;
            fault_sense = '0;
            scans_passed++;
            return stored_verdict();
        end
        cur_line     = cur_line + 1'b1;
        r.drive_line = cur_line;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0d] mismatch on %s: got %0d, want %0d (result %0d)", cycles, what,
                 got, want, beats_checked);
        errors++;
    endtask

    task automatic check_result();
        result_t want;
        if (scan_results_due.size() == 0)
        begin
            report_mismatch("unexpected beat", 1, 0);
            return;
        end
        want = scan_results_due.pop_front();
        if (m_axis_tdata[3:0] != want.drive_line)
            report_mismatch("drive_line", m_axis_tdata[3:0], want.drive_line);
        if (m_axis_tlast != want.done_res)
            report_mismatch("done_res", m_axis_tlast, want.done_res);
        if (m_axis_tdata[4] != want.passed)
            report_mismatch("passed", m_axis_tdata[4], want.passed);
        if (m_axis_tdata[8:5] != want.main_line)
            report_mismatch("main_line", m_axis_tdata[8:5], want.main_line);
        if (m_axis_tdata[9] != want.problem_type)
            report_mismatch("problem_type", m_axis_tdata[9], want.problem_type);
        if (m_axis_tdata[13:10] != want.second_line)
            report_mismatch("second_line", m_axis_tdata[13:10], want.second_line);
        if (m_axis_tdata[15:14] != '0)
            report_mismatch("pad bits", m_axis_tdata[15:14], 0);
        beats_checked++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_result();
    end

    // Receiver: random stall bursts while enabled
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && idle_on && !quiet && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Returns at the accepting edge; valid stays high for a following beat
    task automatic send_beat(logic op, logic [ROW_W-1:0] lv);
        @(negedge clk);
        if (idle_on && !quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= lv;
        scan_results_due.push_back(predict_scan_result(op, lv));
        beats_sent++;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Drop valid and hold until every due result has arrived
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (scan_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_table(int idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_INDEX_W'(idx);
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        conn_table[idx] = val;
        table_writes++;
    endtask

    task automatic fill_table(logic [CFG_DATA_W-1:0] val);
        for (int i = 0; i < CFG_REGS; i++)
            write_table(i, val);
    endtask

    function automatic logic [ROW_W-1:0] matching_levels(logic [LINE_W-1:0] ln);
        logic [ROW_W-1:0] mask;
        mask = checked_mask(ln);
        return (row_of(ln) & mask) | (ROW_W'($urandom) & ~mask);
    endfunction

    task automatic test_idle_readback();
        send_beat(OP_READBACK, 16'hFFFF);
    endtask

    // Restart mid-scan, then a clean pass with ignored bits at both extremes
    task automatic test_restart_and_pass();
        logic [ROW_W-1:0] mask;
        send_beat(OP_START, 16'h0000);
        send_beat(OP_READBACK, matching_levels(0) | 16'h0001);
        send_beat(OP_START, 16'hFFFF);
        for (int ln = 0; ln <= LAST_LINE; ln++)
        begin
            mask = checked_mask(LINE_W'(ln));
            send_beat(OP_READBACK, (row_of(LINE_W'(ln)) & mask) | (ln[0] ? '0 : ~mask));
        end
        send_beat(OP_READBACK, 16'h0000);
    endtask

    task automatic test_fault_kinds();
        wait_idle();
        fill_table('0);
        send_beat(OP_START, 16'h0000);
        send_beat(OP_READBACK, 16'hFFFF);
        send_beat(OP_READBACK, 16'h0000);
        wait_idle();
        fill_table('1);
        send_beat(OP_START, 16'h0000);
        send_beat(OP_READBACK, 16'h7FFF);
    endtask

    task automatic load_random_table();
        logic [CFG_DATA_W-1:0] val;
        for (int i = 0; i < CFG_REGS; i++)
        begin
            case ($urandom_range(0, 3))
                0: val = '0;
                1: val = '1;
                2: val = {$urandom, $urandom};
                default: val = EXPECTED_RESET[i];
            endcase
            write_table(i, val);
        end
    endtask

    // Mostly well-formed scans with occasional faults, restarts and noise
    task automatic run_scans(int n_items, bit pause_midway);
        logic [ROW_W-1:0] lv;
        int               j;
        for (int k = 0; k < n_items; k++)
        begin
            if (pause_midway && k == n_items / 2)
                wait_idle();
            if (k % 60 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (!scanning)
            begin
                if ($urandom_range(0, 6) == 0)
                    send_beat(OP_READBACK, ROW_W'($urandom));
                else
                    send_beat(OP_START, ROW_W'($urandom));
            end
            else if ($urandom_range(0, 40) == 0)
                send_beat(OP_START, ROW_W'($urandom));
            else if ($urandom_range(0, 50) == 0)
                send_beat(OP_READBACK, ROW_W'($urandom));
            else
            begin
                lv = matching_levels(cur_line);
                if (cur_line != LINE_W'(LAST_LINE) && $urandom_range(0, 23) == 0)
                begin
                    j = $urandom_range(int'(cur_line) + 1, LAST_LINE);
                    lv[j] = ~lv[j];
                end
                send_beat(OP_READBACK, lv);
            end
        end
    endtask

    task automatic test_random_scans();
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_idle();
            load_random_table();
            if (phase == 5)
                quiet = 1'b1;
            run_scans(180, phase == 2);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_START;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        errors        = 0;
        cycles        = 0;
        beats_sent    = 0;
        beats_checked = 0;
        scans_passed  = 0;
        shorts_found  = 0;
        opens_found   = 0;
        restarts      = 0;
        table_writes  = 0;
        idle_on       = 1'b1;
        quiet         = 1'b0;
        for (int i = 0; i < CFG_REGS; i++)
            conn_table[i] = EXPECTED_RESET[i];
        scanning    = 1'b0;
        cur_line    = '0;
        verdict_ok  = 1'b0;
        fault_drive = '0;
        fault_kind  = PROBLEM_OPEN;
        fault_sense = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_readback();
        test_restart_and_pass();
        test_fault_kinds();
        test_random_scans();
        wait_idle();

        $display("covered %0d beats, %0d results checked, %0d table writes", beats_sent,
                 beats_checked, table_writes);
        $display("scans passed %0d, shorts %0d, opens %0d, restarts %0d", scans_passed,
                 shorts_found, opens_found, restarts);
        if (errors == 0)
            $display("PASS cable_continuity_scan_unit");
        else
            $display("FAIL cable_continuity_scan_unit");
        $finish;
    end

endmodule
